[design/mst_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and types for the multi-slot software timer.
package mst_pkg;

  localparam int unsigned SLOT_COUNT = 8;
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [15:0] TPS_RESET    = 16'd1000;
  localparam logic [15:0] STROBE_RESET = 16'd50;

  typedef enum logic [2:0] {
    REQ_TICK       = 3'd0,
    REQ_ADD        = 3'd1,
    REQ_RESTART    = 3'd2,
    REQ_DISABLE    = 3'd3,
    REQ_SET_PERIOD = 3'd4,
    REQ_GET_PERIOD = 3'd5,
    REQ_SET_EPOCH  = 3'd6,
    REQ_READ_TIME  = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    KIND_ACK    = 3'd0,
    KIND_FIRED  = 3'd1,
    KIND_STROBE = 3'd2,
    KIND_FULL   = 3'd3,
    KIND_BAD    = 3'd4
  } kind_e;

  typedef enum logic [0:0] {
    CFG_TPS    = 1'b0,
    CFG_STROBE = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_FLUSH = 3'b100
  } state_e;

  // Broadcast to every slot cell; slot ops apply to the selected cell only, scan controls to all.
  typedef struct packed {
    logic        add;
    logic        restart;
    logic        disable_slot;
    logic        set_period;
    logic [31:0] period;
    logic        enable_now;
    logic        repeat_mode;
    logic [31:0] now;
    logic        scan_start;
    logic        scan_step;
    logic        scan_clear;
  } cell_cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  slot_index;
    logic [31:0] value;
    logic [31:0] time_seconds;
    logic [31:0] time_ms;
    logic        last;
  } rsp_t;

endpackage

[design/mst_if.sv]
`timescale 1ns / 1ps
// Handshake interfaces for the request, response and configuration channels.
interface mst_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [2:0]  slot;
  logic [31:0] period;
  logic        enable_now;
  logic        repeat_mode;
  logic [31:0] epoch_value;

  modport source (
    output valid, req_type, slot, period, enable_now, repeat_mode, epoch_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, slot, period, enable_now, repeat_mode, epoch_value,
    output ready
  );
endinterface

interface mst_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [2:0]  slot_index;
  logic [31:0] value;
  logic [31:0] time_seconds;
  logic [31:0] time_ms;
  logic        last;

  modport source (
    output valid, kind, slot_index, value, time_seconds, time_ms, last,
    input  ready
  );
  modport sink (
    input  valid, kind, slot_index, value, time_seconds, time_ms, last,
    output ready
  );
endinterface

interface mst_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/mst_cell.sv]
`timescale 1ns / 1ps
// One timer slot cell: period, start, enable and repeat, plus the scan token.
module mst_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mst_pkg::cell_cmd_t    cmd_i,
  input  logic                  sel_i,
  input  logic                  tok_i,
  output logic                  tok_o,
  output logic                  fire_o,
  output logic [31:0]           period_o
);

  logic [31:0] period_q;
  logic [31:0] start_q;
  logic        en_q;
  logic        rep_q;
  logic        tok_q;
  logic [31:0] elapsed;

  // modular elapsed time, wraps with the ticker
  assign elapsed  = cmd_i.now - start_q;
  assign fire_o   = tok_q & en_q & (elapsed >= period_q);
  assign tok_o    = tok_q;
  assign period_o = period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= '0;
      start_q  <= '0;
      en_q     <= 1'b0;
      rep_q    <= 1'b0;
      tok_q    <= 1'b0;
    end else begin
      if (cmd_i.scan_clear) begin
        tok_q <= 1'b0;
      end else if (cmd_i.scan_start || cmd_i.scan_step) begin
        tok_q <= tok_i;
      end

      if (fire_o && cmd_i.scan_step) begin
        en_q    <= rep_q;
        start_q <= start_q + period_q;
      end else if (sel_i) begin
        if (cmd_i.add) begin
          period_q <= cmd_i.period;
          rep_q    <= cmd_i.repeat_mode;
          en_q     <= cmd_i.enable_now;
          if (cmd_i.enable_now) begin
            start_q <= cmd_i.now;
          end
        end
        if (cmd_i.restart) begin
          start_q <= cmd_i.now;
          en_q    <= 1'b1;
        end
        if (cmd_i.disable_slot) begin
          en_q <= 1'b0;
        end
        if (cmd_i.set_period) begin
          period_q <= cmd_i.period;
        end
      end
    end
  end

endmodule

[design/mst_time.sv]
`timescale 1ns / 1ps
// Millisecond ticker, epoch seconds with sub-second accumulator, strobe counter.
module mst_time (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        tick_i,
  input  logic        epoch_wr_i,
  input  logic [31:0] epoch_val_i,
  input  logic [15:0] tps_i,
  input  logic [15:0] strobe_int_i,
  output logic [31:0] ms_o,
  output logic [31:0] epoch_o,
  output logic        strobe_hit_o
);

  logic [31:0] ms_q, ms_d;
  logic [31:0] epoch_q, epoch_d;
  logic [15:0] frac_q, frac_d;
  logic [15:0] strobe_q, strobe_d;
  logic [15:0] frac_inc;
  logic [15:0] strobe_inc;

  assign frac_inc     = frac_q + 16'd1;
  assign strobe_inc   = strobe_q + 16'd1;
  assign strobe_hit_o = tick_i & (strobe_inc == strobe_int_i);

  always_comb begin
    ms_d     = ms_q;
    epoch_d  = epoch_q;
    frac_d   = frac_q;
    strobe_d = strobe_q;
    if (tick_i) begin
      ms_d = ms_q + 32'd1;
      if (frac_inc >= tps_i) begin
        epoch_d = epoch_q + 32'd1;
        frac_d  = frac_inc - tps_i;
      end else begin
        frac_d = frac_inc;
      end
      strobe_d = strobe_hit_o ? 16'd0 : strobe_inc;
    end
    if (epoch_wr_i) begin
      epoch_d = epoch_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q     <= '0;
      epoch_q  <= '0;
      frac_q   <= '0;
      strobe_q <= '0;
    end else begin
      ms_q     <= ms_d;
      epoch_q  <= epoch_d;
      frac_q   <= frac_d;
      strobe_q <= strobe_d;
    end
  end

  assign ms_o    = ms_q;
  assign epoch_o = epoch_q;

endmodule

[design/multi_slot_software_timer.sv]
`timescale 1ns / 1ps
// Top level: request sequencer, slot cell chain, time counters and response register.
//
//   channel | dir | transaction
//   req     | in  | one request: tick, add, restart, disable, set/get period, epoch, time
//   rsp     | out | one result; last marks the final result of a request
//   cfg     | in  | register write: 0 ticks_per_second, 1 strobe_interval
//
// A non-tick request's result is registered and appears in the next cycle.
// A tick walks a token along the used slot cells, one cell per cycle unless it is held;
// then a flush state drains the held result and, if one is pending, the strobe.
// Results are sent in slot order; the token holds while a new firing finds the held
// one waiting and the response register full and not being read.
// Reset clears all counters and slots; cfg writes are taken at any cycle.
module multi_slot_software_timer (
  input  logic       clk_i,
  input  logic       rst_ni,
  mst_req_if.sink    req,
  mst_rsp_if.source  rsp,
  mst_cfg_if.sink    cfg
);

  localparam int unsigned SC = mst_pkg::SLOT_COUNT;
  localparam int unsigned CW = mst_pkg::CNT_W;
  localparam int unsigned IW = mst_pkg::IDX_W;

  mst_pkg::state_e    state_q, state_d;
  logic [CW-1:0]      used_q, used_d;
  logic [IW-1:0]      pos_q, pos_d;
  logic               hold_valid_q, hold_valid_d;
  logic [IW-1:0]      hold_idx_q, hold_idx_d;
  logic               strobe_pend_q, strobe_pend_d;
  logic [15:0]        tps_q;
  logic [15:0]        strobe_int_q;
  mst_pkg::rsp_t      rsp_q, push_rsp;
  logic               rsp_valid_q;
  logic               push;
  logic               push_ok;
  logic               req_acc;
  mst_pkg::cell_cmd_t cmd;
  logic               tick;
  logic               epoch_wr;
  logic [31:0]        ms;
  logic [31:0]        epoch;
  logic               strobe_hit;
  logic [SC-1:0]      add_sel;
  logic [SC-1:0]      hdl_sel;
  logic [SC-1:0]      sel;
  logic [SC-1:0]      fire;
  logic [SC-1:0]      tok;
  logic [31:0]        cell_period [SC];
  logic [31:0]        rd_period;
  logic               handle_ok;
  logic               fire_any;
  logic               last_pos;
  logic               step;
  mst_pkg::req_e      req_type;

  assign push_ok   = !rsp_valid_q || rsp.ready;
  assign req.ready = (state_q == mst_pkg::S_IDLE) && push_ok;
  assign req_acc   = req.valid && req.ready;
  assign req_type  = mst_pkg::req_e'(req.req_type);
  assign cfg.ready = 1'b1;

  assign handle_ok = int'(req.slot) < int'(used_q);
  assign fire_any  = |fire;
  assign last_pos  = (CW'(pos_q) + CW'(1)) == used_q;
  assign sel       = cmd.add ? add_sel : hdl_sel;

  always_comb begin
    rd_period = '0;
    for (int i = 0; i < SC; i++) begin
      add_sel[i] = int'(used_q) == i;
      hdl_sel[i] = int'(req.slot) == i;
      if (hdl_sel[i]) begin
        rd_period = cell_period[i];
      end
    end
  end

  always_comb begin
    state_d        = state_q;
    used_d         = used_q;
    pos_d          = pos_q;
    hold_valid_d   = hold_valid_q;
    hold_idx_d     = hold_idx_q;
    strobe_pend_d  = strobe_pend_q;
    push           = 1'b0;
    push_rsp       = '0;
    tick           = 1'b0;
    epoch_wr       = 1'b0;
    step           = 1'b0;
    cmd            = '0;
    cmd.period     = req.period;
    cmd.enable_now = req.enable_now;
    cmd.repeat_mode = req.repeat_mode;
    cmd.now        = ms;

    unique case (state_q)
      mst_pkg::S_IDLE: begin
        if (req_acc) begin
          push_rsp.kind = mst_pkg::KIND_ACK;
          push_rsp.last = 1'b1;
          unique case (req_type) inside
            mst_pkg::REQ_TICK: begin
              tick          = 1'b1;
              strobe_pend_d = strobe_hit;
              hold_valid_d  = 1'b0;
              pos_d         = '0;
              if (used_q == '0) begin
                state_d = mst_pkg::S_FLUSH;
              end else begin
                state_d        = mst_pkg::S_SCAN;
                cmd.scan_start = 1'b1;
              end
            end
            mst_pkg::REQ_ADD: begin
              push = 1'b1;
              if (used_q == CW'(SC)) begin
                push_rsp.kind = mst_pkg::KIND_FULL;
              end else begin
                cmd.add             = 1'b1;
                push_rsp.slot_index = 3'(used_q);
                used_d              = used_q + CW'(1);
              end
            end
            mst_pkg::REQ_RESTART, mst_pkg::REQ_DISABLE,
            mst_pkg::REQ_SET_PERIOD, mst_pkg::REQ_GET_PERIOD: begin
              push = 1'b1;
              if (!handle_ok) begin
                push_rsp.kind = mst_pkg::KIND_BAD;
              end else begin
                cmd.restart      = req_type == mst_pkg::REQ_RESTART;
                cmd.disable_slot = req_type == mst_pkg::REQ_DISABLE;
                cmd.set_period   = req_type == mst_pkg::REQ_SET_PERIOD;
                if (req_type == mst_pkg::REQ_GET_PERIOD) begin
                  push_rsp.value = rd_period;
                end
              end
            end
            mst_pkg::REQ_SET_EPOCH: begin
              push     = 1'b1;
              epoch_wr = 1'b1;
            end
            mst_pkg::REQ_READ_TIME: begin
              push                  = 1'b1;
              push_rsp.time_seconds = epoch;
              push_rsp.time_ms      = ms;
            end
            default: begin
              push = 1'b1;
            end
          endcase
        end
      end

      mst_pkg::S_SCAN: begin
        // a new fire pushes out the held one, so it needs the output free
        step = !fire_any || !hold_valid_q || push_ok;
        if (step) begin
          cmd.scan_step = 1'b1;
          if (fire_any) begin
            if (hold_valid_q) begin
              push                = 1'b1;
              push_rsp.kind       = mst_pkg::KIND_FIRED;
              push_rsp.slot_index = 3'(hold_idx_q);
            end
            hold_valid_d = 1'b1;
            hold_idx_d   = pos_q;
          end
          pos_d = pos_q + IW'(1);
          if (last_pos) begin
            cmd.scan_clear = 1'b1;
            state_d        = mst_pkg::S_FLUSH;
          end
        end
      end

      mst_pkg::S_FLUSH: begin
        if (hold_valid_q) begin
          if (push_ok) begin
            push                = 1'b1;
            push_rsp.kind       = mst_pkg::KIND_FIRED;
            push_rsp.slot_index = 3'(hold_idx_q);
            push_rsp.last       = !strobe_pend_q;
            hold_valid_d        = 1'b0;
            if (!strobe_pend_q) begin
              state_d = mst_pkg::S_IDLE;
            end
          end
        end else if (strobe_pend_q) begin
          if (push_ok) begin
            push          = 1'b1;
            push_rsp.kind = mst_pkg::KIND_STROBE;
            push_rsp.last = 1'b1;
            strobe_pend_d = 1'b0;
            state_d       = mst_pkg::S_IDLE;
          end
        end else begin
          state_d = mst_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = mst_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= mst_pkg::S_IDLE;
      used_q        <= '0;
      pos_q         <= '0;
      hold_valid_q  <= 1'b0;
      hold_idx_q    <= '0;
      strobe_pend_q <= 1'b0;
      rsp_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      used_q        <= used_d;
      pos_q         <= pos_d;
      hold_valid_q  <= hold_valid_d;
      hold_idx_q    <= hold_idx_d;
      strobe_pend_q <= strobe_pend_d;
      if (push) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      rsp_q <= push_rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q        <= mst_pkg::TPS_RESET;
      strobe_int_q <= mst_pkg::STROBE_RESET;
    end else if (cfg.valid) begin
      unique case (mst_pkg::cfg_reg_e'(cfg.index))
        mst_pkg::CFG_TPS:    tps_q        <= cfg.data;
        mst_pkg::CFG_STROBE: strobe_int_q <= cfg.data;
        default: ;
      endcase
    end
  end

  mst_time u_time (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick),
    .epoch_wr_i   (epoch_wr),
    .epoch_val_i  (req.epoch_value),
    .tps_i        (tps_q),
    .strobe_int_i (strobe_int_q),
    .ms_o         (ms),
    .epoch_o      (epoch),
    .strobe_hit_o (strobe_hit)
  );

  assign tok[0] = cmd.scan_start;

  for (genvar g = 0; g < SC; g++) begin : g_cell
    if (g == SC - 1) begin : g_tail
      mst_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .cmd_i    (cmd),
        .sel_i    (sel[g]),
        .tok_i    (tok[g]),
        .tok_o    (),
        .fire_o   (fire[g]),
        .period_o (cell_period[g])
      );
    end else begin : g_body
      mst_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .cmd_i    (cmd),
        .sel_i    (sel[g]),
        .tok_i    (tok[g]),
        .tok_o    (tok[g+1]),
        .fire_o   (fire[g]),
        .period_o (cell_period[g])
      );
    end
  end

  assign rsp.valid        = rsp_valid_q;
  assign rsp.kind         = rsp_q.kind;
  assign rsp.slot_index   = rsp_q.slot_index;
  assign rsp.value        = rsp_q.value;
  assign rsp.time_seconds = rsp_q.time_seconds;
  assign rsp.time_ms      = rsp_q.time_ms;
  assign rsp.last         = rsp_q.last;

endmodule

[design/mst_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the multi-slot software timer, with its bind.
module mst_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic [2:0] req_type_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [2:0] rsp_kind_i,
  input logic [2:0] rsp_slot_index_i,
  input logic       rsp_last_i
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_kind_i) &&
    $stable(rsp_slot_index_i) && $stable(rsp_last_i))
    else $error("stalled response changed");

  // a non-tick request answers with a single final result in the next cycle
  a_single_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && (req_type_i != 3'(mst_pkg::REQ_TICK)) |=>
    rsp_valid_i && rsp_last_i)
    else $error("non-tick request without a final result");

  // no new request while a result sequence is still open
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_last_i |-> !req_ready_i)
    else $error("request taken inside a result sequence");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_kind_i <= 3'(mst_pkg::KIND_BAD))
    else $error("undefined result kind");

  // the strobe always closes a tick's results
  a_strobe_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_kind_i == 3'(mst_pkg::KIND_STROBE)) |-> rsp_last_i)
    else $error("strobe not marked last");

endmodule

bind multi_slot_software_timer mst_checker u_mst_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req.valid),
  .req_ready_i      (req.ready),
  .req_type_i       (req.req_type),
  .rsp_valid_i      (rsp.valid),
  .rsp_ready_i      (rsp.ready),
  .rsp_kind_i       (rsp.kind),
  .rsp_slot_index_i (rsp.slot_index),
  .rsp_last_i       (rsp.last)
);
